>>> src/tcfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcfa_pkg;

	localparam int MAX_PER_CLASS_DEF = 16;
	localparam int OUT_W             = 5;
	localparam int LIMIT_W           = 8;

	localparam logic [LIMIT_W-1:0] TURN_LIMIT_RST = 8'd3;
	localparam logic [LIMIT_W-1:0] GRANTS_SAT     = 8'hFF;

	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;
	localparam logic CLS_WHITE   = 1'b0;
	localparam logic CLS_BLACK   = 1'b1;

	typedef struct packed {
		logic               cls;
		logic               valid;
		logic [LIMIT_W-1:0] grants;
	} turn_t;

	typedef struct packed {
		logic [OUT_W-1:0] granted_white;
		logic [OUT_W-1:0] granted_black;
		logic [OUT_W-1:0] active_white_now;
		logic [OUT_W-1:0] active_black_now;
		logic [OUT_W-1:0] waiting_white_now;
		logic [OUT_W-1:0] waiting_black_now;
		logic             error_flag;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic fin;
	} ctrl_stat_t;

endpackage

`default_nettype wire

>>> src/tcfa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcfa_req_if;
	logic valid;
	logic ready;
	logic command;
	logic requester_class;

	modport source (output valid, output command, output requester_class, input ready);
	modport sink   (input valid, input command, input requester_class, output ready);
endinterface

interface tcfa_rsp_if import tcfa_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] granted_white;
	logic [OUT_W-1:0] granted_black;
	logic [OUT_W-1:0] active_white_now;
	logic [OUT_W-1:0] active_black_now;
	logic [OUT_W-1:0] waiting_white_now;
	logic [OUT_W-1:0] waiting_black_now;
	logic             error_flag;

	modport source (output valid, output granted_white, output granted_black,
		output active_white_now, output active_black_now, output waiting_white_now,
		output waiting_black_now, output error_flag, input ready);
	modport sink   (input valid, input granted_white, input granted_black,
		input active_white_now, input active_black_now, input waiting_white_now,
		input waiting_black_now, input error_flag, output ready);
endinterface

interface tcfa_cfg_if import tcfa_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] turn_limit;

	modport source (output valid, output turn_limit, input ready);
	modport sink   (input valid, input turn_limit, output ready);
endinterface

`default_nettype wire

>>> src/two_class_fair_access_arbiter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Port   Dir  Word                                   Handshake
// req    in   command, requester_class               valid/ready
// rsp    out  granted_*, active_*_now, waiting_*_now, error_flag
//                                                    valid/ready
// cfg    in   turn_limit                             valid/ready (always ready)
//
// A word holds the block from accept to next accept through these steps, g being the
// waiters admitted (at most MAX_PER_CLASS, classes exclude): event, the grants one by
// one through the shared admission unit, a failed try per class, hand-off. The hand-off
// writes the result; a rejected word skips the grant pass. One word at a
// time; the result sits in an output register, and a full register stalls the hand-off.
// Reset clears all counts and the turn, and sets turn_limit to 3.
module two_class_fair_access_arbiter_unit import tcfa_pkg::*; #(
	parameter int MAX_PER_CLASS = MAX_PER_CLASS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tcfa_req_if.sink     req,
	tcfa_rsp_if.source   rsp,
	tcfa_cfg_if.sink     cfg
);

	logic [LIMIT_W-1:0] limit_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	ctrl_stat_t         stat;
	rsp_t               res;
	logic               res_take;

	tcfa_ctrl #(.MAX_PER_CLASS(MAX_PER_CLASS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_fire        (req.valid && req.ready),
		.command        (req.command),
		.requester_class(req.requester_class),
		.limit          (limit_q),
		.res_take       (res_take),
		.stat           (stat),
		.res            (res)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = stat.idle;
	assign res_take  = stat.fin && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= TURN_LIMIT_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.turn_limit;
			end
			if (res_take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.granted_white     = rsp_q.granted_white;
	assign rsp.granted_black     = rsp_q.granted_black;
	assign rsp.active_white_now  = rsp_q.active_white_now;
	assign rsp.active_black_now  = rsp_q.active_black_now;
	assign rsp.waiting_white_now = rsp_q.waiting_white_now;
	assign rsp.waiting_black_now = rsp_q.waiting_black_now;
	assign rsp.error_flag        = rsp_q.error_flag;

endmodule

`default_nettype wire

>>> src/tcfa_admit_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// One admission attempt for class cls: decides whether the next waiter
// may enter and gives the state after that grant.
module tcfa_admit_unit import tcfa_pkg::*; #(
	parameter int CNT_W = 5
) (
	input  wire logic                    cls,
	input  wire logic [1:0][CNT_W-1:0]   active,
	input  wire logic [1:0][CNT_W-1:0]   waiting,
	input  wire turn_t                   turn,
	input  wire logic [LIMIT_W-1:0]      limit,
	output logic                         grant,
	output logic      [1:0][CNT_W-1:0]   active_nxt,
	output logic      [1:0][CNT_W-1:0]   waiting_nxt,
	output turn_t                        turn_nxt
);

	logic may_enter;
	logic other_wait;

	assign other_wait = (waiting[~cls] != '0);

	always_comb begin
		if (active[~cls] != '0) begin
			may_enter = 1'b0;
		end else if (active[cls] == '0) begin
			may_enter = !turn.valid || (turn.cls == cls) || !other_wait;
		end else begin
			may_enter = !((turn.grants >= limit) && other_wait);
		end
	end

	assign grant = (waiting[cls] != '0) && may_enter;

	always_comb begin
		active_nxt  = active;
		waiting_nxt = waiting;
		turn_nxt    = turn;
		active_nxt[cls]  = active[cls] + CNT_W'(1);
		waiting_nxt[cls] = waiting[cls] - CNT_W'(1);
		if (!turn.valid || (turn.cls != cls)) begin
			turn_nxt.cls    = cls;
			turn_nxt.valid  = 1'b1;
			turn_nxt.grants = LIMIT_W'(1);
		end else if (turn.grants != GRANTS_SAT) begin
			turn_nxt.grants = turn.grants + LIMIT_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> src/tcfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Arbiter state and the sequencer that drives the shared admission unit.
module tcfa_ctrl import tcfa_pkg::*; #(
	parameter int MAX_PER_CLASS = MAX_PER_CLASS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire logic               command,
	input  wire logic               requester_class,
	input  wire logic [LIMIT_W-1:0] limit,
	input  wire logic               res_take,
	output ctrl_stat_t              stat,
	output rsp_t                    res
);

	localparam int CNT_W = $clog2(MAX_PER_CLASS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVENT = 2'd1;
	localparam logic [1:0] ST_ADMIT = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]            state_q;
	logic                  cmd_q;
	logic                  evcls_q;
	logic                  err_q;
	logic                  cls_q;
	logic                  phase_q;
	logic [1:0][CNT_W-1:0] active_q;
	logic [1:0][CNT_W-1:0] waiting_q;
	logic [1:0][CNT_W-1:0] gcnt_q;
	turn_t                 turn_q;

	logic                  ev_err;
	logic [1:0][CNT_W-1:0] ev_active;
	logic [1:0][CNT_W-1:0] ev_waiting;
	turn_t                 ev_turn;
	logic [CNT_W:0]        occ;

	logic                  grant;
	logic [1:0][CNT_W-1:0] ad_active;
	logic [1:0][CNT_W-1:0] ad_waiting;
	turn_t                 ad_turn;

	tcfa_admit_unit #(.CNT_W(CNT_W)) u_admit (
		.cls        (cls_q),
		.active     (active_q),
		.waiting    (waiting_q),
		.turn       (turn_q),
		.limit      (limit),
		.grant      (grant),
		.active_nxt (ad_active),
		.waiting_nxt(ad_waiting),
		.turn_nxt   (ad_turn)
	);

	assign occ = {1'b0, active_q[evcls_q]} + {1'b0, waiting_q[evcls_q]};

	// request or release of the latched event
	always_comb begin
		ev_err     = 1'b0;
		ev_active  = active_q;
		ev_waiting = waiting_q;
		ev_turn    = turn_q;
		if (cmd_q == CMD_REQUEST) begin
			if (occ >= (CNT_W + 1)'(MAX_PER_CLASS)) begin
				ev_err = 1'b1;
			end else begin
				ev_waiting[evcls_q] = waiting_q[evcls_q] + CNT_W'(1);
			end
		end else begin
			if (active_q[evcls_q] == '0) begin
				ev_err = 1'b1;
			end else begin
				ev_active[evcls_q] = active_q[evcls_q] - CNT_W'(1);
				if (active_q[evcls_q] == CNT_W'(1)) begin
					if (waiting_q[~evcls_q] != '0) begin
						ev_turn.cls    = ~evcls_q;
						ev_turn.valid  = 1'b1;
						ev_turn.grants = '0;
					end else begin
						ev_turn.valid = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= '0;
			waiting_q <= '0;
			turn_q    <= '0;
			gcnt_q    <= '0;
			err_q     <= 1'b0;
			cls_q     <= CLS_WHITE;
			phase_q   <= 1'b0;
			cmd_q     <= CMD_REQUEST;
			evcls_q   <= CLS_WHITE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q   <= command;
						evcls_q <= requester_class;
						state_q <= ST_EVENT;
					end
				end
				ST_EVENT: begin
					err_q     <= ev_err;
					gcnt_q    <= '0;
					active_q  <= ev_active;
					waiting_q <= ev_waiting;
					turn_q    <= ev_turn;
					// turn class first, white when no turn holds
					cls_q     <= ev_turn.valid ? ev_turn.cls : CLS_WHITE;
					phase_q   <= 1'b0;
					state_q   <= ev_err ? ST_FIN : ST_ADMIT;
				end
				ST_ADMIT: begin
					if (grant) begin
						active_q      <= ad_active;
						waiting_q     <= ad_waiting;
						turn_q        <= ad_turn;
						gcnt_q[cls_q] <= gcnt_q[cls_q] + CNT_W'(1);
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						cls_q   <= ~cls_q;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.fin  = (state_q == ST_FIN);

	assign res.granted_white     = OUT_W'(gcnt_q[CLS_WHITE]);
	assign res.granted_black     = OUT_W'(gcnt_q[CLS_BLACK]);
	assign res.active_white_now  = OUT_W'(active_q[CLS_WHITE]);
	assign res.active_black_now  = OUT_W'(active_q[CLS_BLACK]);
	assign res.waiting_white_now = OUT_W'(waiting_q[CLS_WHITE]);
	assign res.waiting_black_now = OUT_W'(waiting_q[CLS_BLACK]);
	assign res.error_flag        = err_q;

endmodule

`default_nettype wire
